[rtl/core/qltu_pkg.sv]
// Shared types and constants for the Q-learning table update block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package qltu_pkg;

   localparam int NUM_STATES_DEF = 8;
   localparam int Q_WIDTH_DEF    = 32;

   localparam int RATE_W = 17;
   localparam logic [RATE_W-1:0] ALPHA_RESET = 17'd32768;
   localparam logic [RATE_W-1:0] GAMMA_RESET = 17'd58982;
   localparam logic [RATE_W-1:0] ONE_FX      = 17'h10000;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_ALPHA = 1'b0;
   localparam logic CSR_IDX_GAMMA = 1'b1;

   localparam logic [7:0] REWARD_BLOCKED = 8'hFF;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_STEP  = 2'd1,
      FUNC_INFER = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RSCAN,
      ST_CHECK,
      ST_MOD,
      ST_SELECT,
      ST_RDSA,
      ST_CAPSA,
      ST_NSCAN,
      ST_MUL,
      ST_ACC,
      ST_ISCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SCAN_REWARD,
      SCAN_NEXT,
      SCAN_INFER
   } scan_kind_type;

   typedef enum logic [2:0] {
      RES_PLAIN,
      RES_LOAD,
      RES_NONE,
      RES_STEP,
      RES_INFER
   } res_kind_type;

   typedef enum logic [2:0] {
      OP_QHI,
      OP_QLO,
      OP_MHI,
      OP_MLO,
      OP_THI,
      OP_TLO
   } mul_op_type;

   typedef struct packed {
      logic          latch;
      logic          clr;
      logic          scan;
      scan_kind_type scan_kind;
      logic          mod_init;
      logic          mod_step;
      logic          sel;
      logic          rd_sa;
      logic          cap_sa;
      logic          mul;
      logic          acc;
      logic          emit;
      res_kind_type  res_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic     clr_last;
      logic     scan_last;
      logic     cnt_zero;
      logic     mod_last;
      logic     sel_hit;
      logic     op_last;
      logic     out_free;
      func_type func;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/qltu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module qltu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/qltu_dpath.sv]
// Datapath: reward and Q table memories, row scans, modulo unit, shared
// multiplier, accumulators and result register. Depends on qltu_pkg, qltu_ram.
`default_nettype none

module qltu_dpath #(
   parameter int NUM_STATES = qltu_pkg::NUM_STATES_DEF,
   parameter int Q_WIDTH    = qltu_pkg::Q_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire qltu_pkg::dp_cmd_type   cmd_i,
   output qltu_pkg::dp_status_type     status_o,
   input  wire qltu_pkg::func_type     req_func_i,
   input  wire logic [2:0]             req_state_in_i,
   input  wire logic [2:0]             req_column_i,
   input  wire logic [7:0]             req_reward_i,
   input  wire logic [15:0]            req_pick_i,
   input  wire logic [2:0]             req_restart_i,
   input  wire logic [16:0]            alpha_i,
   input  wire logic [16:0]            gamma_i,
   input  wire logic                   rsp_ready_i,
   output logic                        rsp_valid_o,
   output logic [2:0]                  rsp_action_o,
   output logic [2:0]                  rsp_next_state_o,
   output logic [31:0]                 rsp_q_value_o,
   output logic                        rsp_episode_end_o,
   output logic                        rsp_no_action_o
);
   import qltu_pkg::*;

   localparam int SW  = $clog2(NUM_STATES);
   localparam int CW  = SW + 1;
   localparam int MW  = $clog2(NUM_STATES * NUM_STATES);
   localparam int TW  = ((Q_WIDTH > 23) ? Q_WIDTH : 23) + 1;
   localparam int QAW = TW + 1;
   localparam int MA  = ((TW - 16) > 16) ? (TW - 16) : 16;
   localparam int PW  = MA + RATE_W;

   function automatic logic [MW-1:0] tab_addr(input logic [SW-1:0] r, input logic [SW-1:0] c);
      tab_addr = MW'(int'(r) * NUM_STATES + int'(c));
   endfunction

   function automatic logic [SW-1:0] wrap_state(input logic [2:0] v);
      int t;
      t = int'(v);
      for (int k = 0; k < 4; k++) begin
         if (t >= NUM_STATES) t = t - NUM_STATES;
      end
      wrap_state = SW'(t);
   endfunction

   function automatic logic [31:0] sat32(input logic [Q_WIDTH-1:0] v);
      if (64'(v) > 64'h0000_0000_FFFF_FFFF) sat32 = 32'hFFFF_FFFF;
      else sat32 = 32'(v);
   endfunction

   // control registers
   logic [SW-1:0]    cur_ff, cur_in;
   logic [MW-1:0]    clr_ff, clr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rsp_vld_ff, rsp_vld_in;
   // payload registers
   logic [SW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [SW-1:0]    row_ff, row_in;
   func_type         func_ff, func_in;
   logic [2:0]       sin_ff, sin_in, col_ff, col_in, rst_ff, rst_in;
   logic [7:0]       rew_ff, rew_in;
   logic [15:0]      pick_ff, pick_in;
   logic [NUM_STATES-1:0] mask_ff, mask_in;
   logic [CW-1:0]    cnt_ff, cnt_in, rem_ff, rem_in;
   logic [3:0]       modc_ff, modc_in;
   logic [SW-1:0]    sel_ff, sel_in, act_ff, act_in, best_act_ff, best_act_in;
   logic [Q_WIDTH-1:0] maxq_ff, maxq_in, best_ff, best_in, qsa_ff, qsa_in;
   logic [6:0]       r_ff, r_in;
   mul_op_type       op_ff, op_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [QAW-1:0]   qacc_ff, qacc_in;
   logic [TW-1:0]    tacc_ff, tacc_in;
   logic [2:0]       res_action_ff, res_action_in, res_next_ff, res_next_in;
   logic [31:0]      res_q_ff, res_q_in;
   logic             res_end_ff, res_end_in, res_none_ff, res_none_in;

   logic [7:0]         rew_rd, rew_wr_data;
   logic [Q_WIDTH-1:0] q_rd, q_wr_data, q_next;
   logic               rew_wr_en, q_wr_en;
   logic [MW-1:0]      rew_wr_addr, q_wr_addr, rd_addr;
   logic [RATE_W-1:0]  a_eff, g_eff, b_eff;
   logic [MA-1:0]      mul_a;
   logic [RATE_W-1:0]  mul_b;
   logic [CW:0]        mod_sh;
   logic               out_free, allowed_rd;

   qltu_ram #(.WIDTH(8), .DEPTH(NUM_STATES * NUM_STATES)) u_reward_ram (
      .clock   (clock),
      .wr_en   (rew_wr_en),
      .wr_addr (rew_wr_addr),
      .wr_data (rew_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rew_rd)
   );

   qltu_ram #(.WIDTH(Q_WIDTH), .DEPTH(NUM_STATES * NUM_STATES)) u_q_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (rd_addr),
      .rd_data (q_rd)
   );

   assign out_free   = !rsp_vld_ff || rsp_ready_i;
   assign allowed_rd = !rew_rd[7];
   assign a_eff = (alpha_i > ONE_FX) ? ONE_FX : alpha_i;
   assign g_eff = (gamma_i > ONE_FX) ? ONE_FX : gamma_i;
   assign b_eff = ONE_FX - a_eff;
   assign q_next = (qacc_ff > QAW'({Q_WIDTH{1'b1}})) ? {Q_WIDTH{1'b1}} : qacc_ff[Q_WIDTH-1:0];
   assign rd_addr = cmd_i.rd_sa ? tab_addr(cur_ff, act_ff) : tab_addr(row_ff, SW'(idx_ff));
   assign mod_sh  = {rem_ff, pick_ff[15]};

   // shared multiplier operand select
   always_comb begin
      case (op_ff)
         OP_QHI: begin mul_a = MA'(qsa_ff >> 16);    mul_b = b_eff; end
         OP_QLO: begin mul_a = MA'(qsa_ff[15:0]);    mul_b = b_eff; end
         OP_MHI: begin mul_a = MA'(maxq_ff >> 16);   mul_b = g_eff; end
         OP_MLO: begin mul_a = MA'(maxq_ff[15:0]);   mul_b = g_eff; end
         OP_THI: begin mul_a = MA'(tacc_ff >> 16);   mul_b = a_eff; end
         OP_TLO: begin mul_a = MA'(tacc_ff[15:0]);   mul_b = a_eff; end
         default: begin mul_a = '0;                  mul_b = '0;    end
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      cur_in = cur_ff;  clr_in = clr_ff;  rd_vld_in = 1'b0;
      rsp_vld_in = rsp_vld_ff && !rsp_ready_i;
      rd_idx_in = rd_idx_ff;  idx_in = idx_ff;  row_in = row_ff;
      func_in = func_ff;  sin_in = sin_ff;  col_in = col_ff;  rst_in = rst_ff;
      rew_in = rew_ff;  pick_in = pick_ff;  mask_in = mask_ff;  cnt_in = cnt_ff;
      rem_in = rem_ff;  modc_in = modc_ff;  sel_in = sel_ff;  act_in = act_ff;
      best_act_in = best_act_ff;  maxq_in = maxq_ff;  best_in = best_ff;
      qsa_in = qsa_ff;  r_in = r_ff;  op_in = op_ff;
      qacc_in = qacc_ff;  tacc_in = tacc_ff;
      res_action_in = res_action_ff;  res_next_in = res_next_ff;  res_q_in = res_q_ff;
      res_end_in = res_end_ff;  res_none_in = res_none_ff;
      rew_wr_en = 1'b0;  rew_wr_addr = clr_ff;  rew_wr_data = REWARD_BLOCKED;
      q_wr_en = 1'b0;    q_wr_addr = clr_ff;    q_wr_data = '0;

      if (cmd_i.clr) begin
         rew_wr_en = 1'b1;
         q_wr_en   = 1'b1;
         clr_in    = clr_ff + 1'b1;
      end

      if (cmd_i.latch) begin
         func_in = req_func_i;  sin_in = req_state_in_i;  col_in = req_column_i;
         rew_in = req_reward_i;  pick_in = req_pick_i;  rst_in = req_restart_i;
         idx_in = '0;  cnt_in = '0;  mask_in = '0;  best_in = '0;  best_act_in = '0;
         row_in = (req_func_i == FUNC_STEP) ? cur_ff : wrap_state(req_state_in_i);
      end

      // issue one read per cycle; process the data of the previous read
      if (cmd_i.scan) begin
         if (idx_ff < CW'(NUM_STATES)) begin
            rd_vld_in = 1'b1;
            rd_idx_in = SW'(idx_ff);
            idx_in    = idx_ff + 1'b1;
         end
         if (rd_vld_ff) begin
            case (cmd_i.scan_kind)
               SCAN_REWARD: begin
                  mask_in[rd_idx_ff] = allowed_rd;
                  cnt_in = cnt_ff + CW'(allowed_rd);
               end
               SCAN_NEXT: begin
                  if (allowed_rd && q_rd > maxq_ff) maxq_in = q_rd;
               end
               SCAN_INFER: begin
                  if (q_rd > best_ff) begin
                     best_in     = q_rd;
                     best_act_in = rd_idx_ff;
                  end
               end
               default: ;
            endcase
         end
      end

      if (cmd_i.mod_init) begin
         rem_in = '0;  modc_in = '0;  sel_in = '0;
      end

      // restoring remainder, one pick bit per step
      if (cmd_i.mod_step) begin
         pick_in = {pick_ff[14:0], 1'b0};
         modc_in = modc_ff + 1'b1;
         if (mod_sh >= {1'b0, cnt_ff}) rem_in = CW'(mod_sh - {1'b0, cnt_ff});
         else rem_in = CW'(mod_sh);
      end

      if (cmd_i.sel) begin
         if (mask_ff[sel_ff]) begin
            if (rem_ff == '0) act_in = sel_ff;
            else rem_in = rem_ff - 1'b1;
         end
         sel_in = sel_ff + 1'b1;
      end

      if (cmd_i.cap_sa) begin
         r_in = rew_rd[6:0];  qsa_in = q_rd;
         row_in = act_ff;  idx_in = '0;  maxq_in = '0;  op_in = OP_QHI;
      end

      if (cmd_i.acc) begin
         case (op_ff)
            OP_QHI: qacc_in = QAW'(prod_ff);
            OP_QLO: qacc_in = qacc_ff + QAW'(prod_ff >> 16);
            OP_MHI: tacc_in = TW'(prod_ff) + (TW'(r_ff) << 16);
            OP_MLO: tacc_in = tacc_ff + TW'(prod_ff >> 16);
            OP_THI: qacc_in = qacc_ff + QAW'(prod_ff);
            OP_TLO: qacc_in = qacc_ff + QAW'(prod_ff >> 16);
            default: ;
         endcase
         op_in = mul_op_type'(op_ff + 1'b1);
      end

      if (cmd_i.emit) begin
         rsp_vld_in    = 1'b1;
         res_action_in = '0;
         res_q_in      = '0;
         res_end_in    = 1'b0;
         res_none_in   = 1'b0;
         case (cmd_i.res_kind)
            RES_LOAD: begin
               // drop a load outside the table
               if (int'(sin_ff) < NUM_STATES && int'(col_ff) < NUM_STATES) begin
                  rew_wr_en   = 1'b1;
                  rew_wr_addr = tab_addr(SW'(sin_ff), SW'(col_ff));
                  rew_wr_data = rew_ff;
               end
            end
            RES_NONE: res_none_in = 1'b1;
            RES_STEP: begin
               q_wr_en   = 1'b1;
               q_wr_addr = tab_addr(cur_ff, act_ff);
               q_wr_data = q_next;
               res_action_in = 3'(act_ff);
               res_q_in      = sat32(q_next);
               if (act_ff == SW'(NUM_STATES - 1)) begin
                  res_end_in = 1'b1;
                  cur_in     = wrap_state(rst_ff);
               end else begin
                  cur_in = act_ff;
               end
            end
            RES_INFER: begin
               res_action_in = 3'(best_act_ff);
               res_q_in      = sat32(best_ff);
            end
            default: ;
         endcase
         res_next_in = 3'(cur_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         clr_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cur_ff     <= cur_in;
         clr_ff     <= clr_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;  idx_ff <= idx_in;  row_ff <= row_in;
      func_ff <= func_in;  sin_ff <= sin_in;  col_ff <= col_in;  rst_ff <= rst_in;
      rew_ff <= rew_in;  pick_ff <= pick_in;  mask_ff <= mask_in;  cnt_ff <= cnt_in;
      rem_ff <= rem_in;  modc_ff <= modc_in;  sel_ff <= sel_in;  act_ff <= act_in;
      best_act_ff <= best_act_in;  maxq_ff <= maxq_in;  best_ff <= best_in;
      qsa_ff <= qsa_in;  r_ff <= r_in;  op_ff <= op_in;
      prod_ff <= cmd_i.mul ? prod_in : prod_ff;
      qacc_ff <= qacc_in;  tacc_ff <= tacc_in;
      res_action_ff <= res_action_in;  res_next_ff <= res_next_in;  res_q_ff <= res_q_in;
      res_end_ff <= res_end_in;  res_none_ff <= res_none_in;
   end

   always_comb begin
      status_o.clr_last  = (clr_ff == MW'(NUM_STATES * NUM_STATES - 1));
      status_o.scan_last = rd_vld_ff && (rd_idx_ff == SW'(NUM_STATES - 1));
      status_o.cnt_zero  = (cnt_ff == '0);
      status_o.mod_last  = (modc_ff == 4'd15);
      status_o.sel_hit   = mask_ff[sel_ff] && (rem_ff == '0);
      status_o.op_last   = (op_ff == OP_TLO);
      status_o.out_free  = out_free;
      status_o.func      = func_ff;
   end

   assign rsp_valid_o       = rsp_vld_ff;
   assign rsp_action_o      = res_action_ff;
   assign rsp_next_state_o  = res_next_ff;
   assign rsp_q_value_o     = res_q_ff;
   assign rsp_episode_end_o = res_end_ff;
   assign rsp_no_action_o   = res_none_ff;

endmodule

`default_nettype wire

[rtl/core/qltu_ctrl.sv]
// Controller state machine: sequences clearing, scans, modulo, selection,
// multiply-accumulate and result emission. Depends on qltu_pkg.
`default_nettype none

module qltu_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid_i,
   input  wire qltu_pkg::func_type      req_func_i,
   input  wire qltu_pkg::dp_status_type status_i,
   output logic                         req_tready_o,
   output qltu_pkg::dp_cmd_type         cmd_o
);
   import qltu_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready_o = (state_ff == ST_IDLE);
   assign accept       = req_tready_o && req_tvalid_i;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (status_i.clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               case (req_func_i)
                  FUNC_STEP:  state_in = ST_RSCAN;
                  FUNC_INFER: state_in = ST_ISCAN;
                  default:    state_in = ST_EMIT;
               endcase
            end
         end
         ST_RSCAN:  if (status_i.scan_last) state_in = ST_CHECK;
         ST_CHECK:  state_in = status_i.cnt_zero ? ST_EMIT : ST_MOD;
         ST_MOD:    if (status_i.mod_last) state_in = ST_SELECT;
         ST_SELECT: if (status_i.sel_hit) state_in = ST_RDSA;
         ST_RDSA:   state_in = ST_CAPSA;
         ST_CAPSA:  state_in = ST_NSCAN;
         ST_NSCAN:  if (status_i.scan_last) state_in = ST_MUL;
         ST_MUL:    state_in = ST_ACC;
         ST_ACC:    state_in = status_i.op_last ? ST_EMIT : ST_MUL;
         ST_ISCAN:  if (status_i.scan_last) state_in = ST_EMIT;
         ST_EMIT:   if (status_i.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_o = '0;
      cmd_o.scan_kind = SCAN_REWARD;
      cmd_o.res_kind  = RES_PLAIN;
      case (state_ff)
         ST_CLEAR:  cmd_o.clr = 1'b1;
         ST_IDLE:   cmd_o.latch = accept;
         ST_RSCAN:  cmd_o.scan = 1'b1;
         ST_CHECK:  cmd_o.mod_init = 1'b1;
         ST_MOD:    cmd_o.mod_step = 1'b1;
         ST_SELECT: cmd_o.sel = 1'b1;
         ST_RDSA:   cmd_o.rd_sa = 1'b1;
         ST_CAPSA:  cmd_o.cap_sa = 1'b1;
         ST_NSCAN: begin
            cmd_o.scan      = 1'b1;
            cmd_o.scan_kind = SCAN_NEXT;
         end
         ST_MUL:    cmd_o.mul = 1'b1;
         ST_ACC:    cmd_o.acc = 1'b1;
         ST_ISCAN: begin
            cmd_o.scan      = 1'b1;
            cmd_o.scan_kind = SCAN_INFER;
         end
         ST_EMIT: begin
            // hold until the result register is free
            cmd_o.emit = status_i.out_free;
            case (status_i.func)
               FUNC_LOAD:  cmd_o.res_kind = RES_LOAD;
               FUNC_STEP:  cmd_o.res_kind = status_i.cnt_zero ? RES_NONE : RES_STEP;
               FUNC_INFER: cmd_o.res_kind = RES_INFER;
               default:    cmd_o.res_kind = RES_PLAIN;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd_o.emit |-> status_i.out_free)
      else $error("result emitted while result register busy");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted transaction not started");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD || state_ff == ST_SELECT) |-> !status_i.cnt_zero)
      else $error("action selection with no allowed action");

endmodule

`default_nettype wire

[rtl/core/q_learning_table_update.sv]
// Top level of the Q-learning table update block: stream ports, APB-style
// register port, controller and datapath. Depends on qltu_pkg, qltu_ctrl, qltu_dpath.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   req_tdata, req_tuser (func)
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata, rsp_tuser (flags)
//   csr      in         csr_psel/csr_penable    csr_paddr, csr_pwdata, csr_prdata
//
// One transaction at a time. A load goes straight to the emit state, an infer does
// one row scan (one Q entry read per cycle through the RAM read port), and a step
// does two row scans, a 16-step remainder, a 1..N step action search and six passes
// of the shared multiplier, or only the first scan if no action is allowed. After
// reset a clearing pass fills both tables; req_tready stays low during it. A finished
// result waits in the output register while the next transaction is taken; a stalled
// rsp side holds the block in its emit state only when a second result is ready.
`default_nettype none

module q_learning_table_update #(
   parameter int NUM_STATES = qltu_pkg::NUM_STATES_DEF,
   parameter int Q_WIDTH    = qltu_pkg::Q_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // state_in[2:0], column[5:3], reward[13:6], pick[29:14], restart_state[32:30]
   input  wire logic [qltu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func[1:0]
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // action[2:0], next_state[5:3], q_value[37:6]
   output logic [qltu_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // episode_end[0], no_action[1]
   output logic [1:0]                            rsp_tuser,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [qltu_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [qltu_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [qltu_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import qltu_pkg::*;

   logic [RATE_W-1:0] alpha_ff, alpha_in, gamma_ff, gamma_in;
   logic              csr_wr;
   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [2:0]        rsp_action, rsp_next_state;
   logic [31:0]       rsp_q_value;
   logic              rsp_episode_end, rsp_no_action;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      alpha_in = alpha_ff;
      gamma_in = gamma_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_IDX_ALPHA: alpha_in = csr_pwdata[RATE_W-1:0];
            CSR_IDX_GAMMA: gamma_in = csr_pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         gamma_ff <= GAMMA_RESET;
      end else begin
         alpha_ff <= alpha_in;
         gamma_ff <= gamma_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_GAMMA) ? CSR_DATA_W'(gamma_ff)
                                                       : CSR_DATA_W'(alpha_ff);

   qltu_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid_i (req_tvalid),
      .req_func_i   (func_type'(req_tuser)),
      .status_i     (status),
      .req_tready_o (req_tready),
      .cmd_o        (cmd)
   );

   qltu_dpath #(.NUM_STATES(NUM_STATES), .Q_WIDTH(Q_WIDTH)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (cmd),
      .status_o          (status),
      .req_func_i        (func_type'(req_tuser)),
      .req_state_in_i    (req_tdata[2:0]),
      .req_column_i      (req_tdata[5:3]),
      .req_reward_i      (req_tdata[13:6]),
      .req_pick_i        (req_tdata[29:14]),
      .req_restart_i     (req_tdata[32:30]),
      .alpha_i           (alpha_ff),
      .gamma_i           (gamma_ff),
      .rsp_ready_i       (rsp_tready),
      .rsp_valid_o       (rsp_tvalid),
      .rsp_action_o      (rsp_action),
      .rsp_next_state_o  (rsp_next_state),
      .rsp_q_value_o     (rsp_q_value),
      .rsp_episode_end_o (rsp_episode_end),
      .rsp_no_action_o   (rsp_no_action)
   );

   assign rsp_tdata = {2'b00, rsp_q_value, rsp_next_state, rsp_action};
   assign rsp_tuser = {rsp_no_action, rsp_episode_end};

endmodule

`default_nettype wire

[sim/q_learning_table_update_tb.sv]
// Self-checking testbench for q_learning_table_update: directed table, then random
// load/step/infer traffic under several rate settings. Depends on qltu_pkg and the RTL.
`default_nettype none

module q_learning_table_update_tb;
   import qltu_pkg::*;

   localparam int N           = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 70;
   localparam int IDLE_PCT    = 37;
   localparam int CALM_START  = 4000;
   localparam int CALM_STOP   = 9000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ALPHA = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_GAMMA = 3'd4;
   localparam logic [63:0] Q_CEIL = 64'hFFFF_FFFF;

   typedef struct {
      logic [2:0]  action;
      logic [2:0]  next_state;
      logic [31:0] q_value;
      logic        episode_end;
      logic        no_action;
   } outcome_type;

   typedef struct {
      func_type    fn;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [7:0]  rew;
      logic [15:0] pick;
      logic [2:0]  restart;
      bit          typed;
      outcome_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic [63:0] q_mem [N*N];
   logic [7:0]  reward_mem [N*N];
   logic [2:0]  cur_state;
   logic [16:0] alpha_r;
   logic [16:0] gamma_r;

   outcome_type  pending_q[$];
   stim_row_type directed_rows[$];
   int           cycles = 0;
   int           fail_count = 0;
   bit           hold_request = 0;

   q_learning_table_update dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic logic [63:0] frac_mul(logic [63:0] x, logic [63:0] f);
      return (x >> 16) * f + (((x & 64'hFFFF) * f) >> 16);
   endfunction

   function automatic bool_allowed(logic [2:0] s, logic [2:0] a);
      return !reward_mem[s*N + a][7];
   endfunction

   function automatic outcome_type learn_update(stim_row_type it);
      outcome_type o;
      int cnt, idx, act;
      logic [63:0] maxq, a, g, r, target, qn;
      o = '{default: '0};
      cnt = 0;
      act = 0;
      maxq = 0;
      case (it.fn)
         FUNC_LOAD: reward_mem[it.row*N + it.col] = it.rew;
         FUNC_INFER: begin
            for (int i = 0; i < N; i++)
               if (q_mem[it.row*N + i] > maxq) begin
                  maxq = q_mem[it.row*N + i];
                  o.action = 3'(i);
               end
            o.q_value = maxq[31:0];
         end
         FUNC_STEP: begin
            for (int i = 0; i < N; i++)
               if (bool_allowed(cur_state, 3'(i))) cnt++;
            if (cnt == 0) begin
               o.no_action = 1'b1;
            end else begin
               idx = it.pick % cnt;
               for (int i = 0; i < N; i++)
                  if (bool_allowed(cur_state, 3'(i))) begin
                     if (idx == 0) begin
                        act = i;
                        break;
                     end
                     idx--;
                  end
               for (int i = 0; i < N; i++)
                  if (bool_allowed(3'(act), 3'(i)) && q_mem[act*N + i] > maxq)
                     maxq = q_mem[act*N + i];
               a = (alpha_r > ONE_FX) ? 64'd65536 : 64'(alpha_r);
               g = (gamma_r > ONE_FX) ? 64'd65536 : 64'(gamma_r);
               r = 64'(reward_mem[cur_state*N + act] & 8'h7F);
               target = r * 65536 + frac_mul(maxq, g);
               qn = frac_mul(q_mem[cur_state*N + act], 65536 - a) + frac_mul(target, a);
               if (qn > Q_CEIL) qn = Q_CEIL;
               q_mem[cur_state*N + act] = qn;
               o.action = 3'(act);
               o.q_value = qn[31:0];
               if (act == N - 1) begin
                  cur_state = it.restart;
                  o.episode_end = 1'b1;
               end else begin
                  cur_state = 3'(act);
               end
            end
         end
         default: ;
      endcase
      o.next_state = cur_state;
      return o;
   endfunction

   function automatic void add_row(func_type fn, int row, int col, int rew, int pick, int rst,
                                   bit typed, int want_act, int want_ns, bit want_none);
      stim_row_type r;
      r.fn = fn;
      r.row = 3'(row);
      r.col = 3'(col);
      r.rew = 8'(rew);
      r.pick = 16'(pick);
      r.restart = 3'(rst);
      r.typed = typed;
      r.want = '{action: 3'(want_act), next_state: 3'(want_ns), q_value: 32'd0,
                 episode_end: 1'b0, no_action: want_none};
      directed_rows.push_back(r);
   endfunction

   task automatic send_item(stim_row_type it);
      outcome_type o;
      if (!(cycles >= CALM_START && cycles < CALM_STOP) && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.fn;
      req_tdata  <= {7'b0, it.restart, it.pick, it.rew, it.col, it.row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = learn_update(it);
      pending_q.push_back(it.typed ? it.want : o);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [16:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_ALPHA) alpha_r = val;
      else gamma_r = val;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // receive side: check each transaction, then pick the next ready level
   initial begin
      outcome_type w;
      int hold_left;
      bit held;
      hold_left = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_q.size() == 0) begin
               $error("unexpected result: tdata=%h tuser=%h", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               w = pending_q.pop_front();
               if (rsp_tdata[2:0] !== w.action) begin
                  $error("action: expected %0d, got %0d", w.action, rsp_tdata[2:0]);
                  fail_count++;
               end
               if (rsp_tdata[5:3] !== w.next_state) begin
                  $error("next_state: expected %0d, got %0d", w.next_state, rsp_tdata[5:3]);
                  fail_count++;
               end
               if (rsp_tdata[37:6] !== w.q_value) begin
                  $error("q_value: expected %h, got %h", w.q_value, rsp_tdata[37:6]);
                  fail_count++;
               end
               if (rsp_tuser[0] !== w.episode_end) begin
                  $error("episode_end: expected %b, got %b", w.episode_end, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[1] !== w.no_action) begin
                  $error("no_action: expected %b, got %b", w.no_action, rsp_tuser[1]);
                  fail_count++;
               end
            end
         end
         if (hold_request && !held) begin
            held = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (cycles >= CALM_START && cycles < CALM_STOP) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      stim_row_type it;
      int u;
      for (int i = 0; i < N*N; i++) begin
         q_mem[i] = '0;
         reward_mem[i] = REWARD_BLOCKED;
      end
      cur_state = '0;
      alpha_r = ALPHA_RESET;
      gamma_r = GAMMA_RESET;

      // nothing allowed yet, empty Q table, unused code
      add_row(FUNC_STEP,  0, 0, 0, 16'hFFFF, 7, 1, 0, 0, 1);
      add_row(FUNC_INFER, 7, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(FUNC_NOP,   7, 7, 8'h7F, 16'hFFFF, 7, 1, 0, 0, 0);
      add_row(FUNC_LOAD,  0, 0, 8'h00, 0, 0, 1, 0, 0, 0);
      add_row(FUNC_LOAD,  0, 7, 8'h7F, 16'hFFFF, 7, 1, 0, 0, 0);
      add_row(FUNC_LOAD,  7, 2, 8'h80, 0, 0, 1, 0, 0, 0);
      add_row(FUNC_LOAD,  7, 3, 8'h05, 0, 0, 1, 0, 0, 0);
      add_row(FUNC_LOAD,  3, 7, 8'h64, 0, 0, 1, 0, 0, 0);
      add_row(FUNC_LOAD,  3, 0, 8'hFF, 0, 0, 1, 0, 0, 0);
      add_row(FUNC_LOAD,  7, 7, 8'h7F, 0, 0, 1, 0, 0, 0);
      add_row(FUNC_STEP,  0, 0, 0, 16'hFFFF, 3, 0, 0, 0, 0);
      add_row(FUNC_STEP,  0, 0, 0, 16'h0000, 7, 0, 0, 0, 0);
      add_row(FUNC_STEP,  0, 0, 0, 16'h0001, 5, 0, 0, 0, 0);
      add_row(FUNC_STEP,  0, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
      add_row(FUNC_STEP,  0, 0, 0, 16'hFFFF, 7, 0, 0, 0, 0);
      add_row(FUNC_STEP,  0, 0, 0, 16'h0003, 7, 0, 0, 0, 0);
      add_row(FUNC_INFER, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_INFER, 3, 5, 8'h80, 16'hFFFF, 7, 0, 0, 0, 0);
      add_row(FUNC_INFER, 7, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(FUNC_NOP,   3, 2, 8'h55, 16'h1234, 4, 0, 0, 0, 0);
      add_row(FUNC_STEP,  0, 0, 0, 16'h7FFF, 2, 0, 0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) send_item(directed_rows[k]);

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin write_reg(ADDR_ALPHA, 17'h10000); write_reg(ADDR_GAMMA, 17'h10000); end
            1: begin write_reg(ADDR_ALPHA, 17'h00000); write_reg(ADDR_GAMMA, 17'h00000); end
            2: begin write_reg(ADDR_ALPHA, 17'h1FFFF); write_reg(ADDR_GAMMA, 17'h00001); end
            3: begin write_reg(ADDR_ALPHA, 17'h00001); write_reg(ADDR_GAMMA, 17'h1FFFF); end
            default: begin
               write_reg(ADDR_ALPHA, 17'($urandom_range(65536)));
               write_reg(ADDR_GAMMA, 17'($urandom_range(65536)));
            end
         endcase
         // fill the reward table, mostly allowed moves, then train on it
         for (int k = 0; k < N*N; k++) begin
            it = '{fn: FUNC_LOAD, default: '0};
            it.row = 3'(k / N);
            it.col = 3'(k % N);
            it.rew = ($urandom_range(99) < 75) ? 8'($urandom_range(127))
                                               : 8'($urandom_range(128, 255));
            it.pick = 16'($urandom());
            it.restart = 3'($urandom());
            send_item(it);
         end
         for (int k = 0; k < 100; k++) begin
            if (phase == 1 && k == 20) hold_request = 1;
            it = '{fn: FUNC_NOP, default: '0};
            u = $urandom_range(99);
            it.fn = (u < 10) ? FUNC_LOAD : (u < 80) ? FUNC_STEP : (u < 95) ? FUNC_INFER : FUNC_NOP;
            it.row = 3'($urandom());
            it.col = 3'($urandom());
            it.rew = 8'($urandom());
            it.pick = 16'($urandom());
            it.restart = 3'($urandom());
            send_item(it);
         end
      end
      drain();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

[q_learning_table_update.f]
rtl/core/qltu_pkg.sv
rtl/core/qltu_ram.sv
rtl/core/qltu_dpath.sv
rtl/core/qltu_ctrl.sv
rtl/core/q_learning_table_update.sv
sim/q_learning_table_update_tb.sv
